// ===== rtl/mcd_pkg.sv =====
package mcd_pkg;

    localparam int TIME_W     = 32;
    localparam int WIN_W      = 16;
    localparam int WHEEL_W    = 8;
    localparam int COUNT_W    = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_CLICK_WIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MULTI_WIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WHEEL     = 2'd2;

    localparam logic [WIN_W-1:0]   CLICK_WIN_RST = 16'd250;
    localparam logic [WIN_W-1:0]   MULTI_WIN_RST = 16'd500;
    localparam logic [WHEEL_W-1:0] WHEEL_RST     = 8'd24;

    typedef struct packed {
        logic [WIN_W-1:0]   click_win;
        logic [WIN_W-1:0]   multi_win;
        logic [WHEEL_W-1:0] wheel_mask;
    } t_cfg;

    typedef struct packed {
        logic moved;
        logic pressed;
        logic released;
        logic clicked;
        logic hovering;
        logic dragging;
    } t_flags;

endpackage

// ===== rtl/mcd_rpt_if.sv =====
interface mcd_rpt_if #(
    parameter int COORD_BITS  = 12,
    parameter int BUTTON_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic [COORD_BITS-1:0]  pos_x;
    logic [COORD_BITS-1:0]  pos_y;
    logic [BUTTON_BITS-1:0] buttons;
    logic [31:0]            time_ms;

    modport source (output valid, output pos_x, output pos_y, output buttons,
                    output time_ms, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input buttons,
                    input time_ms, output ready);
endinterface

// ===== rtl/mcd_res_if.sv =====
interface mcd_res_if #(
    parameter int COORD_BITS  = 12,
    parameter int BUTTON_BITS = 8
);
    logic                   valid;
    logic                   ready;
    logic                   moved;
    logic [COORD_BITS-1:0]  prev_x;
    logic [COORD_BITS-1:0]  prev_y;
    logic                   pressed;
    logic                   released;
    logic                   clicked;
    logic                   hovering;
    logic                   dragging;
    logic [BUTTON_BITS-1:0] changed_buttons;
    logic [7:0]             click_count;

    modport source (output valid, output moved, output prev_x, output prev_y,
                    output pressed, output released, output clicked,
                    output hovering, output dragging, output changed_buttons,
                    output click_count, input ready);
    modport sink   (input valid, input moved, input prev_x, input prev_y,
                    input pressed, input released, input clicked,
                    input hovering, input dragging, input changed_buttons,
                    input click_count, output ready);
endinterface

// ===== rtl/mcd_core.sv =====
module mcd_core #(
    parameter int COORD_BITS  = 12,
    parameter int BUTTON_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  mcd_pkg::t_cfg                 i_cfg,
    input  logic [COORD_BITS-1:0]         i_pos_x,
    input  logic [COORD_BITS-1:0]         i_pos_y,
    input  logic [BUTTON_BITS-1:0]        i_buttons,
    input  logic [mcd_pkg::TIME_W-1:0]    i_time_ms,
    output mcd_pkg::t_flags               o_flags,
    output logic [COORD_BITS-1:0]         o_prev_x,
    output logic [COORD_BITS-1:0]         o_prev_y,
    output logic [BUTTON_BITS-1:0]        o_changed,
    output logic [mcd_pkg::COUNT_W-1:0]   o_count
);
    import mcd_pkg::*;

    logic [COORD_BITS-1:0]  r_cur_x, r_cur_y, r_press_x, r_press_y;
    logic [BUTTON_BITS-1:0] r_held, r_press_btn;
    logic [TIME_W-1:0]      r_last_rpt, r_last_click;
    logic [COUNT_W-1:0]     r_clicks;

    logic [BUTTON_BITS-1:0] n_held;
    logic [COUNT_W-1:0]     n_clicks;
    logic [BUTTON_BITS+WHEEL_W-1:0] wheel_ext;
    logic [BUTTON_BITS-1:0] wheel_b;
    logic [TIME_W-1:0]      dt_rpt, dt_click;
    logic                   is_press, is_release, click_ok, in_multi;
    t_flags                 flags;
    logic [BUTTON_BITS-1:0] changed;

    assign wheel_ext = {{BUTTON_BITS{1'b0}}, i_cfg.wheel_mask};
    assign wheel_b   = wheel_ext[BUTTON_BITS-1:0];

    assign dt_rpt   = i_time_ms - r_last_rpt;
    assign dt_click = i_time_ms - r_last_click;

    assign is_press   = i_buttons > r_held;
    assign is_release = i_buttons < r_held;

    always_comb begin
        changed = '0;
        if (is_press) begin
            changed = i_buttons & ~r_held;
        end else if (is_release) begin
            changed = ~i_buttons & r_held;
        end
    end

    // stored position after this report is always the new one
    assign click_ok = is_release && (i_buttons == '0) && (changed == r_press_btn)
                      && (i_pos_x == r_press_x) && (i_pos_y == r_press_y)
                      && (dt_rpt <= {{(TIME_W-WIN_W){1'b0}}, i_cfg.click_win});
    assign in_multi = dt_click <= {{(TIME_W-WIN_W){1'b0}}, i_cfg.multi_win};

    always_comb begin
        n_clicks = r_clicks;
        if (click_ok) begin
            if (!in_multi) begin
                n_clicks = COUNT_W'(1);
            end else if (r_clicks != COUNT_MAX) begin
                n_clicks = r_clicks + COUNT_W'(1);
            end
        end else if (is_release) begin
            n_clicks = '0;
        end
    end

    assign n_held = i_buttons & ~wheel_b;

    always_comb begin
        flags.moved    = (i_pos_x != r_cur_x) || (i_pos_y != r_cur_y);
        flags.pressed  = is_press;
        flags.released = is_release;
        flags.clicked  = click_ok;
        flags.hovering = !is_press && !is_release;
        flags.dragging = !is_press && !is_release && (i_buttons != '0);
    end

    assign o_flags   = flags;
    assign o_prev_x  = r_cur_x;
    assign o_prev_y  = r_cur_y;
    assign o_changed = changed;
    assign o_count   = n_clicks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x      <= '0;
            r_cur_y      <= '0;
            r_held       <= '0;
            r_press_btn  <= '0;
            r_press_x    <= '0;
            r_press_y    <= '0;
            r_last_rpt   <= '0;
            r_last_click <= '0;
            r_clicks     <= '0;
        end else if (i_adv) begin
            r_cur_x    <= i_pos_x;
            r_cur_y    <= i_pos_y;
            r_held     <= n_held;
            r_last_rpt <= i_time_ms;
            r_clicks   <= n_clicks;
            if (is_press) begin
                r_press_btn <= changed;
                r_press_x   <= i_pos_x;
                r_press_y   <= i_pos_y;
            end
            if (click_ok) begin
                r_last_click <= i_time_ms;
            end
        end
    end

endmodule

// ===== rtl/mouse_click_detector.sv =====
// Pointer report classifier with multi-click counting. Each report (position,
// button mask, wrapping millisecond timestamp) yields one result: movement with
// the previous position, press / release / hover classification, drag, the
// changed button bits, and a click flag with a saturating click count. The
// block takes one report per clock cycle unless a stall holds it; a report
// passes from the input register to the result register, and a stalled
// result register holds the pipeline back only when both registers are full.
// The pointer and click state update from the input register as each report
// advances, setting the one-report-per-cycle rate. The window and wheel-mask
// registers may be written only while no report is in flight.
module mouse_click_detector #(
    parameter int COORD_BITS  = 12,
    parameter int BUTTON_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [mcd_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mcd_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    mcd_rpt_if.sink                           i_rpt,
    mcd_res_if.source                         o_res
);
    import mcd_pkg::*;

    t_cfg                   r_cfg;

    logic                   r_in_vld;
    logic [COORD_BITS-1:0]  r_in_x, r_in_y;
    logic [BUTTON_BITS-1:0] r_in_btn;
    logic [TIME_W-1:0]      r_in_time;

    logic                   r_out_vld;
    t_flags                 r_flags;
    logic [COORD_BITS-1:0]  r_prev_x, r_prev_y;
    logic [BUTTON_BITS-1:0] r_changed;
    logic [COUNT_W-1:0]     r_count;

    logic                   adv, in_rdy;
    t_flags                 core_flags;
    logic [COORD_BITS-1:0]  core_prev_x, core_prev_y;
    logic [BUTTON_BITS-1:0] core_changed;
    logic [COUNT_W-1:0]     core_count;

    // item moves from the input register to the result register
    assign adv    = r_in_vld && (!r_out_vld || o_res.ready);
    assign in_rdy = !r_in_vld || adv;

    assign i_rpt.ready = in_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_win  <= CLICK_WIN_RST;
            r_cfg.multi_win  <= MULTI_WIN_RST;
            r_cfg.wheel_mask <= WHEEL_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CLICK_WIN: r_cfg.click_win  <= i_cfg_data;
                REG_MULTI_WIN: r_cfg.multi_win  <= i_cfg_data;
                REG_WHEEL:     r_cfg.wheel_mask <= i_cfg_data[WHEEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_rdy) begin
            r_in_vld <= i_rpt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_rdy && i_rpt.valid) begin
            r_in_x    <= i_rpt.pos_x;
            r_in_y    <= i_rpt.pos_y;
            r_in_btn  <= i_rpt.buttons;
            r_in_time <= i_rpt.time_ms;
        end
    end

    mcd_core #(
        .COORD_BITS  (COORD_BITS),
        .BUTTON_BITS (BUTTON_BITS)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_cfg     (r_cfg),
        .i_pos_x   (r_in_x),
        .i_pos_y   (r_in_y),
        .i_buttons (r_in_btn),
        .i_time_ms (r_in_time),
        .o_flags   (core_flags),
        .o_prev_x  (core_prev_x),
        .o_prev_y  (core_prev_y),
        .o_changed (core_changed),
        .o_count   (core_count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_flags   <= core_flags;
            r_prev_x  <= core_prev_x;
            r_prev_y  <= core_prev_y;
            r_changed <= core_changed;
            r_count   <= core_count;
        end
    end

    assign o_res.valid           = r_out_vld;
    assign o_res.moved           = r_flags.moved;
    assign o_res.prev_x          = r_prev_x;
    assign o_res.prev_y          = r_prev_y;
    assign o_res.pressed         = r_flags.pressed;
    assign o_res.released        = r_flags.released;
    assign o_res.clicked         = r_flags.clicked;
    assign o_res.hovering        = r_flags.hovering;
    assign o_res.dragging        = r_flags.dragging;
    assign o_res.changed_buttons = r_changed;
    assign o_res.click_count     = r_count;

    a_one_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> $onehot({r_flags.pressed, r_flags.released, r_flags.hovering}))
        else $error("result not exactly one of press, release, hover");

    a_click_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_flags.clicked |-> r_flags.released && r_count != '0)
        else $error("click without release or with zero count");

    a_hover_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_flags.hovering |-> r_changed == '0)
        else $error("hover with changed buttons");

    a_drag_is_hover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_flags.dragging |-> r_flags.hovering)
        else $error("drag outside hover");

    a_plain_release_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_flags.released && !r_flags.clicked |-> r_count == '0)
        else $error("non-click release kept the click count");

    a_no_lost_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && !adv |=> r_in_vld)
        else $error("pending item dropped from input register");

endmodule
